// ===== src/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, constants and bit helpers for the hierarchical bitmap search.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  localparam int WORD_BITS    = 32;
  localparam int IDX_W        = 15;
  localparam int SIZE_W       = 16;
  localparam int MAP_BITS_DEF = 32768;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'h8000;

  localparam logic [2:0] MODE_FILL  = 3'd0;
  localparam logic [2:0] MODE_SET   = 3'd1;
  localparam logic [2:0] MODE_CLEAR = 3'd2;
  localparam logic [2:0] MODE_TEST  = 3'd3;
  localparam logic [2:0] MODE_LOW   = 3'd4;
  localparam logic [2:0] MODE_ABOVE = 3'd5;
  localparam logic [2:0] MODE_BELOW = 3'd6;

  typedef struct packed {
    logic [2:0]       mode;
    logic [IDX_W-1:0] bit_index;
    logic             fill_value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             was_set;
    logic             map_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RD_LEAF,
    ST_RD_MID,
    ST_DESC_MID,
    ST_DESC_LEAF,
    ST_DONE
  } state_t;

  function automatic logic [4:0] pick_bit(input logic [31:0] x, input logic high);
    logic [4:0] r;
    r = '0;
    if (high) begin
      for (int i = 0; i < 32; i++) begin
        if (x[i]) r = 5'(i);
      end
    end else begin
      for (int i = 31; i >= 0; i--) begin
        if (x[i]) r = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] mask_below(input logic [4:0] b);
    return (32'd1 << b) - 32'd1;
  endfunction

  function automatic logic [31:0] mask_above(input logic [4:0] b);
    return ~((32'd2 << b) - 32'd1);
  endfunction

endpackage

`default_nettype wire

// ===== src/hbs_fill_pattern.sv =====
// ----------------------------------------------------------------------------
// hbs_fill_pattern
// Leaf, summary and top words of a map filled with ones up to a given size.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_fill_pattern import hbs_pkg::*; #(
  parameter int LW_AW = 10
) (
  input  wire logic [SIZE_W-1:0] size,
  input  wire logic [LW_AW-1:0]  word,
  output logic [31:0]            leaf_word,
  output logic [31:0]            mid_word,
  output logic [31:0]            top_word
);

  logic [SIZE_W-1:0] word_ext;
  logic [SIZE_W-1:0] full_words;
  logic [SIZE_W-1:0] used_words;
  logic [SIZE_W-1:0] mid_base;
  logic [SIZE_W-1:0] used_mids;

  assign word_ext   = SIZE_W'(word);
  assign full_words = size >> 5;
  assign used_words = SIZE_W'((17'(size) + 17'd31) >> 5);
  assign mid_base   = (word_ext >> 5) << 5;
  assign used_mids  = (used_words + SIZE_W'(31)) >> 5;

  always_comb begin
    if (word_ext < full_words) begin
      leaf_word = '1;
    end else if (word_ext == full_words) begin
      leaf_word = mask_below(size[4:0]);
    end else begin
      leaf_word = '0;
    end
    if (used_words >= mid_base + SIZE_W'(32)) begin
      mid_word = '1;
    end else if (used_words > mid_base) begin
      mid_word = mask_below(5'(used_words - mid_base));
    end else begin
      mid_word = '0;
    end
    if (used_mids >= SIZE_W'(32)) begin
      top_word = '1;
    end else begin
      top_word = mask_below(used_mids[4:0]);
    end
  end

endmodule

`default_nettype wire

// ===== src/hierarchical_bitmap_search_core.sv =====
// ----------------------------------------------------------------------------
// hierarchical_bitmap_search_core
// Three-level bitmap with set, clear, test, fill and nearest-set-bit search.
// ----------------------------------------------------------------------------
// Each request is handled alone. A search climbs and descends the levels
// through reads of the leaf memory and the summary memory. A fill rewrites
// every leaf word, one per cycle. After reset the same sweep clears the map,
// during which requests are stalled. The size register can be written at
// any time while no request is in flight.
`default_nettype none

module hierarchical_bitmap_search_core import hbs_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  localparam int LEAF_WORDS = MAP_BITS / WORD_BITS;
  localparam int MID_WORDS  = LEAF_WORDS / WORD_BITS;
  localparam int LW_AW      = $clog2(LEAF_WORDS);
  localparam int MID_AW     = (MID_WORDS > 1) ? $clog2(MID_WORDS) : 1;
  localparam logic [LW_AW-1:0] LAST_WORD = LW_AW'(LEAF_WORDS - 1);

  state_t state, state_next;

  logic [LW_AW-1:0]     cnt;
  logic                 sw_ones;
  logic                 fill_req;
  logic [2:0]           mode_r;
  logic [IDX_W-1:0]     p_r;
  logic [MID_AW-1:0]    cur_m, cur_m_next;
  logic [LW_AW-1:0]     cur_w, cur_w_next;
  logic                 found_r, found_next;
  logic [IDX_W-1:0]     idx_r, idx_next;
  logic                 was_r, was_next;
  logic [MID_WORDS-1:0] top, top_next;
  logic [SIZE_W-1:0]    size_r;

  logic [31:0] leaf_mem [LEAF_WORDS];
  logic [31:0] mid_mem  [MID_WORDS];
  logic [31:0] leaf_q, mid_q;

  logic              leaf_we, mid_we;
  logic [LW_AW-1:0]  leaf_ra, leaf_wa;
  logic [MID_AW-1:0] mid_ra, mid_wa;
  logic [31:0]       leaf_wd, mid_wd;

  logic [SIZE_W-1:0] eff_s;
  logic              accept, out_free, p_ok, high, is_search;
  logic [LW_AW-1:0]  w_p, w_in;
  logic [MID_AW-1:0] m_p;
  logic [31:0]       top32, leaf_x, mid_x, top_x, bitp, bitw, leaf_clr, mid_clr;
  logic [MID_WORDS-1:0] top_bit;
  logic [31:0]       fp_leaf, fp_mid, fp_top;
  logic              fin;

  hbs_fill_pattern #(.LW_AW(LW_AW)) u_fill (
    .size      (eff_s),
    .word      (cnt),
    .leaf_word (fp_leaf),
    .mid_word  (fp_mid),
    .top_word  (fp_top)
  );

  assign eff_s     = (size_r < SIZE_W'(MAP_BITS)) ? size_r : SIZE_W'(MAP_BITS);
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;
  assign p_ok      = SIZE_W'(req.bit_index) < eff_s;
  assign high      = (mode_r == MODE_BELOW);
  assign is_search = (mode_r == MODE_ABOVE) || (mode_r == MODE_BELOW);
  assign w_p       = p_r[5 +: LW_AW];
  assign w_in      = req.bit_index[5 +: LW_AW];
  assign m_p       = MID_AW'(p_r >> 10);
  assign top32     = 32'(top);
  assign leaf_x    = leaf_q & (high ? mask_below(p_r[4:0]) : mask_above(p_r[4:0]));
  assign mid_x     = mid_q & (high ? mask_below(p_r[9:5]) : mask_above(p_r[9:5]));
  assign top_x     = top32 & (high ? mask_below(p_r[14:10]) : mask_above(p_r[14:10]));
  assign bitp      = 32'd1 << p_r[4:0];
  assign bitw      = 32'd1 << p_r[9:5];
  assign leaf_clr  = leaf_q & ~bitp;
  assign mid_clr   = mid_q & ~bitw;
  assign top_bit   = MID_WORDS'(1) << m_p;

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (cnt == LAST_WORD) state_next = fill_req ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (req.mode)
            MODE_FILL: state_next = ST_SWEEP;
            MODE_SET, MODE_CLEAR, MODE_TEST, MODE_ABOVE, MODE_BELOW: begin
              state_next = p_ok ? ST_RD_LEAF : ST_DONE;
            end
            MODE_LOW: state_next = (top != '0) ? ST_DESC_MID : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_RD_LEAF: begin
        case (mode_r)
          MODE_SET: state_next = (leaf_q == '0) ? ST_RD_MID : ST_DONE;
          MODE_CLEAR: begin
            state_next = (leaf_q != '0 && leaf_clr == '0) ? ST_RD_MID : ST_DONE;
          end
          MODE_ABOVE, MODE_BELOW: state_next = (leaf_x != '0) ? ST_DONE : ST_RD_MID;
          default: state_next = ST_DONE;
        endcase
      end
      ST_RD_MID: begin
        if (is_search && mid_x != '0) begin
          state_next = ST_DESC_LEAF;
        end else if (is_search && top_x != '0) begin
          state_next = ST_DESC_MID;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DESC_MID: state_next = ST_DESC_LEAF;
      ST_DESC_LEAF: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    leaf_we    = 1'b0;
    leaf_wa    = w_p;
    leaf_wd    = leaf_clr;
    leaf_ra    = w_p;
    mid_we     = 1'b0;
    mid_wa     = m_p;
    mid_wd     = mid_clr;
    mid_ra     = m_p;
    top_next   = top;
    cur_m_next = cur_m;
    cur_w_next = cur_w;
    found_next = found_r;
    idx_next   = idx_r;
    was_next   = was_r;
    case (state)
      ST_SWEEP: begin
        leaf_we = 1'b1;
        leaf_wa = cnt;
        leaf_wd = sw_ones ? fp_leaf : '0;
        mid_we  = (cnt[4:0] == 5'd0);
        mid_wa  = MID_AW'(cnt >> 5);
        mid_wd  = sw_ones ? fp_mid : '0;
      end
      ST_IDLE: begin
        leaf_ra    = w_in;
        mid_ra     = MID_AW'(pick_bit(top32, 1'b0));
        cur_m_next = MID_AW'(pick_bit(top32, 1'b0));
        if (accept) begin
          found_next = 1'b0;
          idx_next   = '0;
          was_next   = 1'b0;
          if (req.mode == MODE_FILL) begin
            top_next = req.fill_value ? MID_WORDS'(fp_top) : '0;
          end
        end
      end
      ST_RD_LEAF: begin
        case (mode_r)
          MODE_SET: begin
            leaf_we = 1'b1;
            leaf_wd = leaf_q | bitp;
          end
          MODE_CLEAR: leaf_we = 1'b1;
          MODE_TEST: was_next = leaf_q[p_r[4:0]];
          MODE_ABOVE, MODE_BELOW: begin
            if (leaf_x != '0) begin
              found_next = 1'b1;
              idx_next   = IDX_W'({w_p, pick_bit(leaf_x, high)});
            end
          end
          default: ;
        endcase
      end
      ST_RD_MID: begin
        case (mode_r)
          MODE_SET: begin
            mid_we   = 1'b1;
            mid_wd   = mid_q | bitw;
            top_next = top | top_bit;
          end
          MODE_CLEAR: begin
            mid_we = 1'b1;
            if (mid_clr == '0) top_next = top & ~top_bit;
          end
          default: begin
            if (mid_x != '0) begin
              leaf_ra    = LW_AW'({m_p, pick_bit(mid_x, high)});
              cur_w_next = leaf_ra;
            end else begin
              mid_ra     = MID_AW'(pick_bit(top_x, high));
              cur_m_next = mid_ra;
            end
          end
        endcase
      end
      ST_DESC_MID: begin
        leaf_ra    = LW_AW'({cur_m, pick_bit(mid_q, high)});
        cur_w_next = leaf_ra;
      end
      ST_DESC_LEAF: begin
        found_next = 1'b1;
        idx_next   = IDX_W'({cur_w, pick_bit(leaf_q, high)});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    leaf_q <= leaf_mem[leaf_ra];
    if (mid_we) mid_mem[mid_wa] <= mid_wd;
    mid_q <= mid_mem[mid_ra];
  end

  assign fin = found_r && (SIZE_W'(idx_r) < eff_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      cnt       <= '0;
      sw_ones   <= 1'b0;
      fill_req  <= 1'b0;
      top       <= '0;
      size_r    <= SIZE_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      top   <= top_next;
      if (cfg_valid && cfg_ready) size_r <= cfg_data;
      if (state == ST_SWEEP) cnt <= cnt + LW_AW'(1);
      if (accept) begin
        cnt      <= '0;
        sw_ones  <= req.fill_value;
        fill_req <= (req.mode == MODE_FILL);
      end
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_m   <= cur_m_next;
    cur_w   <= cur_w_next;
    found_r <= found_next;
    idx_r   <= idx_next;
    was_r   <= was_next;
    if (accept) begin
      mode_r <= req.mode;
      p_r    <= req.bit_index;
    end
    if (state == ST_DONE && out_free) begin
      rsp.found       <= fin;
      rsp.found_index <= fin ? idx_r : '0;
      rsp.was_set     <= was_r;
      rsp.map_empty   <= (top == '0);
    end
  end

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> SIZE_W'(rsp.found_index) < eff_s)
    else $error("found index lies beyond the size in use");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.found_index == '0)
    else $error("found index is nonzero on a miss");

  a_leaf_write_state: assert property (@(posedge clk) disable iff (rst)
    leaf_we |-> state == ST_SWEEP || state == ST_RD_LEAF)
    else $error("leaf write outside sweep or update");

  a_mid_state_mode: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_MID |-> mode_r != MODE_TEST && mode_r != MODE_FILL)
    else $error("summary step entered for a test or fill");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hierarchical bitmap search core. A directed
// table covers fills, extremes and every mode; random phases of requests
// under several map sizes follow, each response compared with a local
// model of the three-level bitmap.
// ----------------------------------------------------------------------------
module tb;
  import hbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWORDS = MAP_BITS_DEF / 32;
  localparam int NMID = NWORDS / 32;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall, cfg_valid, cfg_ready;
  req_t req;
  rsp_t rsp;
  logic [SIZE_W-1:0] cfg_data;

  hierarchical_bitmap_search_core i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  logic [31:0] leaf [NWORDS];
  logic [31:0] mid [NMID];
  logic [31:0] top;
  int unsigned map_size;
  rsp_t pending_rsp [$];
  int errors;
  longint cycles;

  typedef struct {
    logic [2:0] mode;
    int unsigned idx;
    logic fv;
    logic known;
    rsp_t want;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned lowest(logic [31:0] x);
    for (int i = 0; i < 32; i++) if (x[i]) return i;
    return 0;
  endfunction

  function automatic int unsigned highest(logic [31:0] x);
    for (int i = 31; i >= 0; i--) if (x[i]) return i;
    return 0;
  endfunction

  function automatic int unsigned pick_pos(logic [31:0] x, logic hi);
    return hi ? highest(x) : lowest(x);
  endfunction

  function automatic logic [31:0] upper_bits(int unsigned b);
    return ~((32'd2 << b) - 32'd1);
  endfunction

  function automatic logic [31:0] lower_bits(int unsigned b);
    return (32'd1 << b) - 32'd1;
  endfunction

  function automatic int unsigned descend_word(int unsigned w, logic hi);
    return w * 32 + pick_pos(leaf[w], hi);
  endfunction

  function automatic int unsigned descend_mid(int unsigned m, logic hi);
    return descend_word(m * 32 + pick_pos(mid[m], hi), hi);
  endfunction

  function automatic rsp_t bitmap_apply(logic [2:0] mode, int unsigned p, logic fv);
    rsp_t r;
    int unsigned w, m, pos;
    logic [31:0] x, oldw;
    logic hit;
    w = p >> 5;
    m = w >> 5;
    pos = 0;
    hit = 1'b0;
    r = '0;
    case (mode)
      MODE_FILL: begin
        top = '0;
        for (int i = 0; i < NMID; i++) mid[i] = '0;
        for (int i = 0; i < NWORDS; i++) begin
          if (!fv || i * 32 >= map_size) leaf[i] = '0;
          else if (map_size - i * 32 >= 32) leaf[i] = '1;
          else leaf[i] = 32'hFFFF_FFFF >> (32 - (map_size - i * 32));
          if (leaf[i] != 0) mid[i >> 5][i & 31] = 1'b1;
        end
        for (int i = 0; i < NMID; i++) if (mid[i] != 0) top[i] = 1'b1;
      end
      MODE_SET: if (p < map_size) begin
        oldw = leaf[w];
        leaf[w][p & 31] = 1'b1;
        if (oldw == 0) begin
          mid[m][w & 31] = 1'b1;
          top[m] = 1'b1;
        end
      end
      MODE_CLEAR: if (p < map_size) begin
        oldw = leaf[w];
        leaf[w][p & 31] = 1'b0;
        if (oldw != 0 && leaf[w] == 0) begin
          mid[m][w & 31] = 1'b0;
          if (mid[m] == 0) top[m] = 1'b0;
        end
      end
      MODE_TEST: if (p < map_size) r.was_set = leaf[w][p & 31];
      MODE_LOW: if (top != 0) begin
        hit = 1'b1;
        pos = descend_mid(lowest(top), 1'b0);
      end
      MODE_ABOVE, MODE_BELOW: if (p < map_size) begin
        logic hi;
        hi = (mode == MODE_BELOW);
        x = leaf[w] & (hi ? lower_bits(p & 31) : upper_bits(p & 31));
        if (x != 0) begin
          hit = 1'b1;
          pos = w * 32 + pick_pos(x, hi);
        end else begin
          x = mid[m] & (hi ? lower_bits(w & 31) : upper_bits(w & 31));
          if (x != 0) begin
            hit = 1'b1;
            pos = descend_word(m * 32 + pick_pos(x, hi), hi);
          end else begin
            x = top & (hi ? lower_bits(m & 31) : upper_bits(m & 31));
            if (x != 0) begin
              hit = 1'b1;
              pos = descend_mid(pick_pos(x, hi), hi);
            end
          end
        end
      end
      default: ;
    endcase
    if (hit && pos >= map_size) hit = 1'b0;
    r.found = hit;
    r.found_index = hit ? pos[IDX_W-1:0] : '0;
    r.map_empty = (top == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) rsp_stall <= ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 15) == 0) ||
                           ($urandom_range(0, 1) == 1) : 1'b0;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("unexpected response at cycle %0d", cycles);
        errors++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp.found !== e.found) report_mismatch("found", rsp.found, e.found);
        if (rsp.found_index !== e.found_index)
          report_mismatch("found_index", rsp.found_index, e.found_index);
        if (rsp.was_set !== e.was_set) report_mismatch("was_set", rsp.was_set, e.was_set);
        if (rsp.map_empty !== e.map_empty)
          report_mismatch("map_empty", rsp.map_empty, e.map_empty);
      end
    end
  end

  task automatic send_request(logic [2:0] mode, int unsigned p, logic fv, logic known,
                              rsp_t want);
    rsp_t e;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk);
    req_valid <= 1'b1;
    req.mode <= mode;
    req.bit_index <= p[IDX_W-1:0];
    req.fill_value <= fv;
    do @(posedge clk); while (req_stall);
    req_valid <= 1'b0;
    e = bitmap_apply(mode, p, fv);
    if (known && e !== want) begin
      $display("directed row disagrees with model at cycle %0d", cycles);
      errors++;
    end
    pending_rsp.push_back(e);
  endtask

  task automatic drain;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(int unsigned s);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= s[SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    map_size = (s > MAP_BITS_DEF) ? MAP_BITS_DEF : s;
  endtask

  function automatic rsp_t mk(logic f, int unsigned i, logic w, logic e);
    rsp_t r;
    r.found = f;
    r.found_index = i[IDX_W-1:0];
    r.was_set = w;
    r.map_empty = e;
    return r;
  endfunction

  task automatic random_phase(int n, int unsigned sz);
    int unsigned p;
    logic [2:0] mode;
    write_size(sz);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) == 0) mode = MODE_FILL;
      else mode = 3'($urandom_range(1, 7));
      if ($urandom_range(0, 9) < 8) p = $urandom_range(0, (sz > 0 ? sz : 1) - 1) % 32768;
      else p = $urandom_range(0, 32767);
      if (sz <= 64 && $urandom_range(0, 3) == 0) p = $urandom_range(0, 127);
      send_request(mode, p, 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  row_t dir [];

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    map_size = MAP_BITS_DEF;
    top = '0;
    for (int i = 0; i < NWORDS; i++) leaf[i] = '0;
    for (int i = 0; i < NMID; i++) mid[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    dir = '{
      '{MODE_LOW, 0, 0, 1, mk(0, 0, 0, 1)},
      '{MODE_TEST, 32767, 0, 1, mk(0, 0, 0, 1)},
      '{MODE_SET, 32767, 0, 1, mk(0, 0, 0, 0)},
      '{MODE_TEST, 32767, 0, 1, mk(0, 0, 1, 0)},
      '{MODE_LOW, 0, 0, 1, mk(1, 32767, 0, 0)},
      '{MODE_ABOVE, 0, 0, 1, mk(1, 32767, 0, 0)},
      '{MODE_BELOW, 32767, 0, 1, mk(0, 0, 0, 0)},
      '{MODE_SET, 0, 1, 1, mk(0, 0, 0, 0)},
      '{MODE_BELOW, 32767, 0, 1, mk(1, 0, 0, 0)},
      '{MODE_ABOVE, 32767, 0, 1, mk(0, 0, 0, 0)},
      '{MODE_SET, 1055, 0, 0, '0},
      '{MODE_ABOVE, 31, 0, 0, '0},
      '{MODE_BELOW, 1056, 0, 0, '0},
      '{3'd7, 5, 1, 1, mk(0, 0, 0, 0)},
      '{MODE_CLEAR, 0, 0, 0, '0},
      '{MODE_CLEAR, 1055, 0, 0, '0},
      '{MODE_CLEAR, 32767, 0, 1, mk(0, 0, 0, 1)},
      '{MODE_FILL, 0, 1, 1, mk(0, 0, 0, 0)},
      '{MODE_BELOW, 32767, 0, 1, mk(1, 32766, 0, 0)},
      '{MODE_TEST, 12345, 1, 1, mk(0, 0, 1, 0)},
      '{MODE_FILL, 21845, 0, 1, mk(0, 0, 0, 1)}
    };
    foreach (dir[i]) send_request(dir[i].mode, dir[i].idx, dir[i].fv, dir[i].known,
                                  dir[i].want);
    write_size(40);
    send_request(MODE_FILL, 0, 1, 1'b0, '0);
    send_request(MODE_TEST, 40, 0, 1'b1, mk(0, 0, 0, 0));
    send_request(MODE_BELOW, 39, 0, 1'b0, '0);
    write_size(0);
    send_request(MODE_FILL, 0, 1, 1'b1, mk(0, 0, 0, 1));
    random_phase(250, 1);
    random_phase(200, 100);
    random_phase(250, 32768);
    random_phase(150, 1024);
    random_phase(150, 65535);
    random_phase(50, 3000);
    drain();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
